>>> hdl/trsc_pkg.sv
package trsc_pkg;

    localparam int SYM_W         = 6;
    localparam int TABLE_DEPTH   = 64;
    localparam int ALPHABET_SIZE = 37;

    // Rotor stepping thresholds on the character count
    localparam int STEP_ONE_FROM   = 4;
    localparam int STEP_TWO_FROM   = 8;
    localparam int STEP_THREE_FROM = 12;
    localparam int COUNT_W         = 4;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef logic [SYM_W-1:0] sym_t;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_ENCRYPT = 2'd1,
        OP_DECRYPT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ROTOR_ONE   = 2'd0,
        ROTOR_TWO   = 2'd1,
        ROTOR_THREE = 2'd2
    } rotor_t;

    typedef enum logic [1:0] {
        REG_KEY_ONE   = 2'd0,
        REG_KEY_TWO   = 2'd1,
        REG_KEY_THREE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        sym_t one;
        sym_t two;
        sym_t three;
    } offs_t;

    // Reduce any raw 6-bit value into the alphabet by a single compare and subtract
    function automatic sym_t wrap_sym(sym_t v);
        sym_t r;
        r = v;
        for (int i = 0; i < TABLE_DEPTH / ALPHABET_SIZE; i++)
        begin
            if (r >= SYM_W'(ALPHABET_SIZE))
                r = r - SYM_W'(ALPHABET_SIZE);
        end
        return r;
    endfunction

    // Both operands already below the alphabet size
    function automatic sym_t add_mod(sym_t a, sym_t b);
        logic [SYM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= (SYM_W+1)'(ALPHABET_SIZE)) ? SYM_W'(s - (SYM_W+1)'(ALPHABET_SIZE))
                                                  : SYM_W'(s);
    endfunction

    function automatic sym_t sub_mod(sym_t a, sym_t b);
        logic [SYM_W:0] s;
        s = {1'b0, a} + (SYM_W+1)'(ALPHABET_SIZE) - {1'b0, b};
        return (a >= b) ? (a - b) : SYM_W'(s);
    endfunction

endpackage

>>> hdl/trsc_ram.sv
module trsc_ram (
    input  logic               clk,
    input  logic               we,
    input  trsc_pkg::sym_t     waddr,
    input  trsc_pkg::sym_t     wdata,
    input  trsc_pkg::sym_t     raddr,
    output trsc_pkg::sym_t     rdata
);
    import trsc_pkg::*;

    sym_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/trsc_offsets.sv
module trsc_offsets (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            first,
    input  trsc_pkg::offs_t keys,
    output trsc_pkg::offs_t offs_use
);
    import trsc_pkg::*;

    offs_t              offs_reg;
    logic [COUNT_W-1:0] count_reg;
    offs_t              base;
    logic [COUNT_W-1:0] count_base;
    logic [COUNT_W-1:0] count_next;

    always_comb
    begin
        if (first)
        begin
            base.one   = wrap_sym(keys.one);
            base.two   = wrap_sym(keys.two);
            base.three = wrap_sym(keys.three);
            count_base = '0;
        end
        else
        begin
            base       = offs_reg;
            count_base = count_reg;
        end

        // Step the rotors before this character
        offs_use.one   = (count_base >= COUNT_W'(STEP_ONE_FROM))
                       ? add_mod(base.one, SYM_W'(1)) : base.one;
        offs_use.two   = (count_base >= COUNT_W'(STEP_TWO_FROM))
                       ? add_mod(base.two, SYM_W'(1)) : base.two;
        offs_use.three = (count_base >= COUNT_W'(STEP_THREE_FROM))
                       ? add_mod(base.three, SYM_W'(1)) : base.three;

        count_next = (count_base < COUNT_W'(STEP_THREE_FROM)) ? count_base + 1'b1 : count_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offs_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            offs_reg  <= offs_use;
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/trsc_queue.sv
module trsc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           reserve,
    input  logic           push,
    input  trsc_pkg::sym_t push_data,
    input  logic           take,
    output logic           has_room,
    output logic           valid,
    output trsc_pkg::sym_t data
);
    import trsc_pkg::*;

    sym_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] fill_reg;
    logic [QUEUE_CW-1:0] fill_next;
    logic [QUEUE_CW-1:0] credit_reg;
    logic [QUEUE_CW-1:0] credit_next;
    logic                pop;

    assign valid    = (fill_reg != '0);
    assign data     = mem[rd_ptr_reg];
    assign pop      = valid && take;
    // Credits cover results still in the pipeline as well as those held here
    assign has_room = (credit_reg != QUEUE_CW'(QUEUE_DEPTH));

    always_comb
    begin
        fill_next   = fill_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
        credit_next = credit_reg + QUEUE_CW'(reserve) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

endmodule

>>> hdl/three_rotor_substitution_cipher.sv
// Channel   Signals                                       Moves
// request   request_valid/ready, operation, first,        load, encrypt or decrypt
//           rotor_select, table_index, symbol
// result    result_valid/ready, result_symbol             one symbol per en/decrypt
// config    psel, penable, pwrite, paddr, pwdata,         three rotor keys
//           prdata, pready
//
// One request per cycle. A result passes the three rotor lookups, one registered table
// read per stage, before it enters the result queue.
// Each rotor table is read once and written once per cycle, at a fixed stage.
// A result queue of eight entries decouples the output; requests stall only when
// its credits run out. Reset clears keys, offsets, count and the queue; rotor
// tables hold nothing defined until loaded.
module three_rotor_substitution_cipher (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           request_valid,
    output logic                           request_ready,
    input  logic [1:0]                     operation,
    input  logic                           first,
    input  logic [1:0]                     rotor_select,
    input  trsc_pkg::sym_t                 table_index,
    input  trsc_pkg::sym_t                 symbol,

    output logic                           result_valid,
    input  logic                           result_ready,
    output trsc_pkg::sym_t                 result_symbol,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [trsc_pkg::APB_AW-1:0]    paddr,
    input  logic [trsc_pkg::APB_DW-1:0]    pwdata,
    output logic [trsc_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import trsc_pkg::*;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
        sym_t       idx;
        sym_t       val;
        offs_t      offs;
    } stage_t;

    sym_t   key_one_reg;
    sym_t   key_two_reg;
    sym_t   key_three_reg;
    offs_t  keys;
    offs_t  offs_use;

    op_t    op_in;
    logic   accept;
    logic   res_accept;
    logic   known_op;

    logic [2:0] live_reg;
    stage_t     p1_reg;
    stage_t     p2_reg;
    stage_t     p3_reg;
    stage_t     p1_next;

    logic   load_in;
    logic   load_p1;
    logic   load_p2;

    sym_t   fwd0_addr, fwd1_addr, fwd2_addr;
    sym_t   inv0_addr, inv1_addr;
    sym_t   fwd0_q, fwd1_q, fwd2_q;
    sym_t   inv0_q, inv1_q, inv2_q;

    logic   push;
    sym_t   res_value;

    // Configuration
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_one_reg   <= '0;
            key_two_reg   <= '0;
            key_three_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_KEY_ONE:   key_one_reg   <= pwdata[SYM_W-1:0];
                REG_KEY_TWO:   key_two_reg   <= pwdata[SYM_W-1:0];
                REG_KEY_THREE: key_three_reg <= pwdata[SYM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_KEY_ONE:   prdata = APB_DW'(key_one_reg);
            REG_KEY_TWO:   prdata = APB_DW'(key_two_reg);
            REG_KEY_THREE: prdata = APB_DW'(key_three_reg);
            default:       prdata = '0;
        endcase
    end

    assign keys = '{one: key_one_reg, two: key_two_reg, three: key_three_reg};

    // Request decode
    assign op_in      = op_t'(operation);
    assign accept     = request_valid && request_ready;
    assign known_op   = op_in inside {OP_LOAD, OP_ENCRYPT, OP_DECRYPT};
    assign res_accept = accept && (op_in inside {OP_ENCRYPT, OP_DECRYPT});
    assign load_in    = accept && (op_in == OP_LOAD);

    trsc_offsets u_offsets (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (res_accept),
        .first    (first),
        .keys     (keys),
        .offs_use (offs_use)
    );

    always_comb
    begin
        p1_next.op   = op_in;
        p1_next.sel  = rotor_select;
        p1_next.idx  = table_index;
        p1_next.val  = symbol;
        p1_next.offs = offs_use;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else
        begin
            live_reg <= {live_reg[1:0], accept && known_op};
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= p1_next;
        p2_reg <= p1_reg;
        p3_reg <= p2_reg;
    end

    assign load_p1 = live_reg[0] && (p1_reg.op == OP_LOAD);
    assign load_p2 = live_reg[1] && (p2_reg.op == OP_LOAD);

    // Lookup addresses: forward tables run rotor one to three, inverse tables three to one
    assign fwd0_addr = sub_mod(wrap_sym(symbol), offs_use.one);
    assign fwd1_addr = sub_mod(wrap_sym(fwd0_q), p1_reg.offs.two);
    assign inv1_addr = add_mod(wrap_sym(inv2_q), p1_reg.offs.three);
    assign fwd2_addr = sub_mod(wrap_sym(fwd1_q), p2_reg.offs.three);
    assign inv0_addr = add_mod(wrap_sym(inv1_q), p2_reg.offs.two);

    // Each table is written at the stage where it is read, so loads keep request order
    trsc_ram u_fwd0 (
        .clk   (clk),
        .we    (load_in && (rotor_select == ROTOR_ONE)),
        .waddr (table_index),
        .wdata (symbol),
        .raddr (fwd0_addr),
        .rdata (fwd0_q)
    );

    trsc_ram u_inv2 (
        .clk   (clk),
        .we    (load_in && (rotor_select == ROTOR_THREE)),
        .waddr (symbol),
        .wdata (table_index),
        .raddr (symbol),
        .rdata (inv2_q)
    );

    trsc_ram u_fwd1 (
        .clk   (clk),
        .we    (load_p1 && (p1_reg.sel == ROTOR_TWO)),
        .waddr (p1_reg.idx),
        .wdata (p1_reg.val),
        .raddr (fwd1_addr),
        .rdata (fwd1_q)
    );

    trsc_ram u_inv1 (
        .clk   (clk),
        .we    (load_p1 && (p1_reg.sel == ROTOR_TWO)),
        .waddr (p1_reg.val),
        .wdata (p1_reg.idx),
        .raddr (inv1_addr),
        .rdata (inv1_q)
    );

    trsc_ram u_fwd2 (
        .clk   (clk),
        .we    (load_p2 && (p2_reg.sel == ROTOR_THREE)),
        .waddr (p2_reg.idx),
        .wdata (p2_reg.val),
        .raddr (fwd2_addr),
        .rdata (fwd2_q)
    );

    trsc_ram u_inv0 (
        .clk   (clk),
        .we    (load_p2 && (p2_reg.sel == ROTOR_ONE)),
        .waddr (p2_reg.val),
        .wdata (p2_reg.idx),
        .raddr (inv0_addr),
        .rdata (inv0_q)
    );

    assign push      = live_reg[2] && (p3_reg.op != OP_LOAD);
    assign res_value = (p3_reg.op == OP_ENCRYPT) ? wrap_sym(fwd2_q)
                                                 : add_mod(wrap_sym(inv0_q), p3_reg.offs.one);

    trsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .reserve   (res_accept),
        .push      (push),
        .push_data (res_value),
        .take      (result_ready),
        .has_room  (request_ready),
        .valid     (result_valid),
        .data      (result_symbol)
    );

    // A result leaves the pipeline only for an encrypt or decrypt request that went through all its stages
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $past(res_accept, 3))
        else $error("result without a matching request");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ({1'b0, res_value} < (SYM_W+1)'(ALPHABET_SIZE)))
        else $error("result symbol outside the alphabet");

    // With all credits used, at least one result must be waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !request_ready |-> result_valid)
        else $error("request stalled with no result pending");

endmodule
